// ===== sv/multi_channel_software_timer_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Property wrappers shared by the timer table checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SOFTWARE_TIMER_TABLE_TOP_ASSERT_SVH
`define MULTI_CHANNEL_SOFTWARE_TIMER_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define MCST_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCST_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mcst_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer table package
// Types, codes and constants shared by the timer table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcst_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TICK_MS_DEF   = 10;
  localparam int MAX_SLOTS     = 16;
  localparam int CATCHUP_LIMIT = 3;

  localparam int IDX_W    = 4;
  localparam int PERIOD_W = 20;
  localparam int CD_W     = PERIOD_W + 1;
  localparam int CNT_W    = 16;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_START  = 3'd2,
    KIND_CANCEL = 3'd3,
    KIND_RETIME = 3'd4,
    KIND_FREE   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_SHORT     = 2'd2,
    STS_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EVT_REPLY   = 2'd0,
    EVT_FIRED   = 2'd1,
    EVT_EXPIRED = 2'd2
  } evt_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                   in_use;
    logic                   enabled;
    logic                   endless;
    logic [PERIOD_W-1:0]    reload;
    logic signed [CD_W-1:0] countdown;
    logic [CNT_W-1:0]       repeats;
  } slot_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [IDX_W-1:0]    idx;
    logic [PERIOD_W-1:0] period;
    logic                endless;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    elapsed;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic evt_valid;
    evt_e evt;
  } unit_res_t;

endpackage

`default_nettype wire

// ===== sv/multi_channel_software_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// Multi-channel periodic timer table
// Command-driven timer slots held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Usage: drive start with a command (tick, allocate, start, cancel, retime,
// free) on the in_ ports; it is taken at a clock edge with start high and
// busy low. Each slot record sits in one cell of a ring; every accepted item
// of a known kind rotates the ring once, so the slot unit at the head sees
// each slot in ascending order, one per cycle. An item keeps busy high
// through its sweep, whose length is set by the ring length, and its done
// state; a new item is taken only after busy drops again.
// Results leave as beats on the out_ ports, each marked by out_valid for one
// cycle. A command gives one reply beat after the sweep; a tick gives one
// beat per slot that fired or expired, the last marked by out_last, or none.
// The final beat of an item is registered from the done state and driven
// in the cycle where busy has dropped again.
// Unknown kinds are taken and dropped without a beat.
// The receiver cannot stall; beats are never held back.
// Reset clears every slot's control bits and returns the block to idle;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_software_timer_table_top_assert.svh"

module multi_channel_software_timer_table_top
  import mcst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TICK_MS   = TICK_MS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire [2:0]          in_kind,
  input  wire [IDX_W-1:0]    in_timer_index,
  input  wire [PERIOD_W-1:0] in_period_ms,
  input  wire                in_repeat_forever,
  input  wire [CNT_W-1:0]    in_repeat_count,
  input  wire [CNT_W-1:0]    in_elapsed_ticks,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_slot,
  output logic [1:0]         out_event_res,
  output logic               out_last
);

  localparam int SlotsEff = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam logic [IDX_W-1:0] LastPos = IDX_W'(SlotsEff - 1);

  state_e           state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [1:0]       rep_status_r, rep_status_nxt;
  logic [IDX_W-1:0] rep_slot_r, rep_slot_nxt;
  logic             found_r, found_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [1:0]       pend_evt_r, pend_evt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [1:0]       out_evt_r, out_evt_nxt;
  logic             out_last_r, out_last_nxt;
  logic             shift_en;

  slot_t     ring_q [SlotsEff];
  slot_t     ring_d [SlotsEff];
  slot_t     unit_nxt;
  unit_res_t unit_res;

  for (genvar g = 0; g < SlotsEff; g++) begin : g_cell
    if (g == SlotsEff - 1) begin : g_tail
      assign ring_d[g] = unit_nxt;
    end else begin : g_link
      assign ring_d[g] = ring_q[g+1];
    end
    mcst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (ring_d[g]),
      .q        (ring_q[g])
    );
  end

  mcst_slot_unit #(
    .TICK_MS (TICK_MS)
  ) u_unit (
    .cmd   (cmd_r),
    .pos   (pos_r),
    .found (found_r),
    .cur   (ring_q[0]),
    .nxt   (unit_nxt),
    .res   (unit_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      pos_r        <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      found_r      <= found_nxt;
      pos_r        <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    rep_status_r <= rep_status_nxt;
    rep_slot_r   <= rep_slot_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_evt_r   <= pend_evt_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_evt_r    <= out_evt_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cmd_nxt        = cmd_r;
    rep_status_nxt = rep_status_r;
    rep_slot_nxt   = rep_slot_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_evt_nxt   = pend_evt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_evt_nxt    = out_evt_r;
    out_last_nxt   = out_last_r;
    shift_en       = 1'b0;
    busy           = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_nxt.kind    = in_kind;
          cmd_nxt.idx     = in_timer_index;
          cmd_nxt.period  = in_period_ms;
          cmd_nxt.endless = in_repeat_forever;
          cmd_nxt.count   = in_repeat_count;
          cmd_nxt.elapsed = in_elapsed_ticks;
          pos_nxt         = '0;
          found_nxt       = 1'b0;
          pend_valid_nxt  = 1'b0;
          if (in_kind == KIND_ALLOC) begin
            rep_status_nxt = (in_period_ms > PERIOD_W'(TICK_MS)) ? STS_FULL : STS_SHORT;
            rep_slot_nxt   = '0;
          end else begin
            rep_status_nxt = STS_NOT_ALLOC;
            rep_slot_nxt   = in_timer_index;
          end
          if (in_kind <= KIND_FREE) begin
            state_nxt = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        shift_en = 1'b1;
        if (unit_res.hit) begin
          rep_status_nxt = STS_OK;
          if (cmd_r.kind == KIND_ALLOC) begin
            rep_slot_nxt = pos_r;
            found_nxt    = 1'b1;
          end
        end
        if (unit_res.evt_valid) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STS_OK;
            out_slot_nxt   = pend_slot_r;
            out_evt_nxt    = pend_evt_r;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_slot_nxt  = pos_r;
          pend_evt_nxt   = unit_res.evt;
        end
        if (pos_r == LastPos) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
        if (cmd_r.kind == KIND_TICK) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STS_OK;
            out_slot_nxt   = pend_slot_r;
            out_evt_nxt    = pend_evt_r;
            out_last_nxt   = 1'b1;
          end
          pend_valid_nxt = 1'b0;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rep_status_r;
          out_slot_nxt   = rep_slot_r;
          out_evt_nxt    = EVT_REPLY;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_event_res = out_evt_r;
  assign out_last      = out_last_r;

  `MCST_ASSERT_NOW(a_last_beat_idle, out_valid && out_last, !busy, "final beat while sweeping")
  `MCST_ASSERT_NOW(a_reply_is_last, out_valid && (out_event_res == EVT_REPLY), out_last, "reply not final")
  `MCST_ASSERT_NXT(a_accept_sweeps, start && !busy && (in_kind <= KIND_FREE), busy, "no sweep")

endmodule

`default_nettype wire

// ===== sv/mcst_cell.sv =====
// ----------------------------------------------------------------------------
// Timer table cell
// Holds one slot record and passes it to the next cell on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_cell
  import mcst_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   shift_en,
  input  slot_t d_in,
  output slot_t q
);

  slot_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.in_use  <= 1'b0;
      q_r.enabled <= 1'b0;
      q_r.endless <= 1'b0;
      q_r.repeats <= '0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== sv/mcst_slot_unit.sv =====
// ----------------------------------------------------------------------------
// Timer table slot unit
// Applies the current command or tick to the slot record at the ring head.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_slot_unit
  import mcst_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEF
) (
  input  cmd_t             cmd,
  input  logic [IDX_W-1:0] pos,
  input  logic             found,
  input  slot_t            cur,
  output slot_t            nxt,
  output unit_res_t        res
);

  localparam int DivShift = PERIOD_W + $clog2(TICK_MS);
  localparam int ProdW    = DivShift + PERIOD_W;
  localparam longint unsigned DivMul =
    ((64'd1 << DivShift) + longint'(TICK_MS) - 1) / longint'(TICK_MS);

  logic [ProdW-1:0]       prod;
  logic [PERIOD_W-1:0]    quot;
  logic                   period_ok;
  logic                   match;
  logic [CNT_W-1:0]       dec;
  logic signed [CD_W-1:0] cd_dec;

  assign prod      = ProdW'(cmd.period) * ProdW'(DivMul);
  assign quot      = prod[DivShift +: PERIOD_W];
  assign period_ok = cmd.period > PERIOD_W'(TICK_MS);
  assign match     = pos == cmd.idx;
  assign dec       = (cmd.elapsed > CNT_W'(CATCHUP_LIMIT)) ? cmd.elapsed : CNT_W'(1);
  assign cd_dec    = cur.countdown - $signed({{(CD_W-CNT_W){1'b0}}, dec});

  always_comb begin
    nxt           = cur;
    res.hit       = 1'b0;
    res.evt_valid = 1'b0;
    res.evt       = EVT_FIRED;
    unique case (cmd.kind)
      KIND_TICK: begin
        if (cur.in_use && cur.enabled) begin
          if (cd_dec[CD_W-1] || (cd_dec == '0)) begin
            nxt.countdown = {1'b0, cur.reload};
            res.evt_valid = 1'b1;
            if (cur.endless) begin
              res.evt = EVT_FIRED;
            end else if (cur.repeats != '0) begin
              nxt.repeats = cur.repeats - CNT_W'(1);
              res.evt     = EVT_FIRED;
            end else begin
              nxt.in_use = 1'b0;
              res.evt    = EVT_EXPIRED;
            end
          end else begin
            nxt.countdown = cd_dec;
          end
        end
      end
      KIND_ALLOC: begin
        if (period_ok && !found && !cur.in_use) begin
          nxt.in_use    = 1'b1;
          nxt.enabled   = 1'b0;
          nxt.endless   = 1'b0;
          nxt.repeats   = '0;
          nxt.reload    = quot;
          nxt.countdown = {1'b0, quot};
          res.hit       = 1'b1;
        end
      end
      KIND_RETIME: begin
        if (match) begin
          res.hit = 1'b1;
          if (period_ok) begin
            nxt.reload    = quot;
            nxt.countdown = {1'b0, quot};
          end
        end
      end
      KIND_START: begin
        if (match && cur.in_use) begin
          res.hit     = 1'b1;
          nxt.endless = cmd.endless;
          nxt.enabled = 1'b1;
          if (!cmd.endless && (cmd.count != '0)) begin
            nxt.repeats = cmd.count;
          end
        end
      end
      KIND_CANCEL: begin
        if (match && cur.in_use) begin
          res.hit     = 1'b1;
          nxt.enabled = 1'b0;
        end
      end
      KIND_FREE: begin
        if (match && cur.in_use) begin
          res.hit    = 1'b1;
          nxt.in_use = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sim/multi_channel_software_timer_table_top_test.sv =====
// ----------------------------------------------------------------------------
// Timer table testbench
// Sends commands and ticks to the timer table with random gaps between them,
// predicts every reply and fire/expire beat from a shadow copy of the slot
// table, and checks each beat field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_software_timer_table_top_test;
  import mcst_pkg::*;

  localparam int SLOT_CNT     = (NUM_SLOTS_DEF < MAX_SLOTS) ? NUM_SLOTS_DEF : MAX_SLOTS;
  localparam int ITEMS_WANTED = 470;
  localparam int PRINT_CAP    = 100;

  localparam logic [2:0] KIND_RSVD_A = 3'd6;
  localparam logic [2:0] KIND_RSVD_B = 3'd7;

  typedef struct {
    logic [2:0]          kind;
    logic [IDX_W-1:0]    idx;
    logic [PERIOD_W-1:0] period;
    logic                endless;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    elapsed;
    int                  gap;
    bit                  idle_only;
  } cmd_item_t;

  typedef struct {
    status_e          status;
    logic [IDX_W-1:0] slot;
    evt_e             evt;
    logic             last;
  } timer_beat_t;

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                start             = 1'b0;
  logic [2:0]          in_kind           = '0;
  logic [IDX_W-1:0]    in_timer_index    = '0;
  logic [PERIOD_W-1:0] in_period_ms      = '0;
  logic                in_repeat_forever = 1'b0;
  logic [CNT_W-1:0]    in_repeat_count   = '0;
  logic [CNT_W-1:0]    in_elapsed_ticks  = '0;
  logic                busy;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [IDX_W-1:0]    out_slot;
  logic [1:0]          out_event_res;
  logic                out_last;

  multi_channel_software_timer_table_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_timer_index    (in_timer_index),
    .in_period_ms      (in_period_ms),
    .in_repeat_forever (in_repeat_forever),
    .in_repeat_count   (in_repeat_count),
    .in_elapsed_ticks  (in_elapsed_ticks),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_event_res     (out_event_res),
    .out_last          (out_last)
  );

  cmd_item_t   pending_cmds[$];
  timer_beat_t awaited_beats[$];
  cmd_item_t   cmd_on_bus;
  bit          cmd_taken;
  int          idle_cycles;
  bit          rush;

  logic                tbl_used[SLOT_CNT];
  logic                tbl_armed[SLOT_CNT];
  logic                tbl_endless[SLOT_CNT];
  logic [PERIOD_W-1:0] tbl_period[SLOT_CNT];
  int                  tbl_left[SLOT_CNT];
  logic [CNT_W-1:0]    tbl_reps[SLOT_CNT];
  int                  live_slots;

  int mismatches;
  int cmds_taken;
  int beats_checked;
  int fires_seen;
  int expiries_seen;
  int full_replies;
  int catchup_ticks;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("multi_channel_software_timer_table_top_test NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t: mismatch, %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_cmd(input logic [2:0] k, input logic [IDX_W-1:0] ix,
                           input logic [PERIOD_W-1:0] per, input logic en,
                           input logic [CNT_W-1:0] reps, input logic [CNT_W-1:0] el);
    cmd_item_t c;
    c.kind      = k;
    c.idx       = ix;
    c.period    = per;
    c.endless   = en;
    c.count     = reps;
    c.elapsed   = el;
    c.gap       = rush ? 0 : $urandom_range(0, 14);
    c.idle_only = $urandom_range(0, 1);
    pending_cmds.push_back(c);
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return PERIOD_W'($urandom_range(0, TICK_MS_DEF));
    if (roll < 16) return PERIOD_W'($urandom);
    return PERIOD_W'($urandom_range(TICK_MS_DEF + 1, 30 * TICK_MS_DEF));
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return CNT_W'($urandom_range(0, 3));
    if (roll < 70) return CNT_W'($urandom_range(4, 12));
    return CNT_W'($urandom);
  endfunction

  function automatic logic [CNT_W-1:0] pick_elapsed();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return CNT_W'($urandom_range(0, CATCHUP_LIMIT));
    if (roll < 85) return CNT_W'($urandom_range(CATCHUP_LIMIT + 1, 40));
    return CNT_W'($urandom);
  endfunction

  task automatic advance_table(input cmd_item_t c);
    timer_beat_t tick_beats[$];
    timer_beat_t b;
    int          drop;
    b.status = STS_OK;
    b.slot   = c.idx;
    b.evt    = EVT_REPLY;
    b.last   = 1'b1;
    case (c.kind)
      KIND_TICK: begin
        if (live_slots != 0) begin
          drop = (c.elapsed > CATCHUP_LIMIT) ? int'(c.elapsed) : 1;
          if (c.elapsed > CATCHUP_LIMIT) catchup_ticks++;
          for (int i = 0; i < SLOT_CNT; i++) begin
            if (tbl_used[i] && tbl_armed[i]) begin
              tbl_left[i] -= drop;
              if (tbl_left[i] <= 0) begin
                tbl_left[i] = int'(tbl_period[i] / TICK_MS_DEF);
                b.slot = IDX_W'(i);
                b.last = 1'b0;
                if (tbl_endless[i]) begin
                  b.evt = EVT_FIRED;
                end else if (tbl_reps[i] != 0) begin
                  tbl_reps[i]--;
                  b.evt = EVT_FIRED;
                end else begin
                  tbl_used[i] = 1'b0;
                  if (live_slots != 0) live_slots--;
                  b.evt = EVT_EXPIRED;
                end
                if (b.evt == EVT_FIRED) fires_seen++;
                else expiries_seen++;
                tick_beats.push_back(b);
              end
            end
          end
          if (tick_beats.size() != 0) tick_beats[tick_beats.size() - 1].last = 1'b1;
          foreach (tick_beats[j]) awaited_beats.push_back(tick_beats[j]);
        end
      end
      KIND_ALLOC: begin
        b.slot = '0;
        if (c.period <= TICK_MS_DEF) begin
          b.status = STS_SHORT;
        end else begin
          b.status = STS_FULL;
          for (int i = 0; i < SLOT_CNT; i++) begin
            if (!tbl_used[i] && b.status == STS_FULL) begin
              tbl_used[i]    = 1'b1;
              tbl_armed[i]   = 1'b0;
              tbl_endless[i] = 1'b0;
              tbl_reps[i]    = '0;
              tbl_period[i]  = c.period;
              tbl_left[i]    = int'(c.period / TICK_MS_DEF);
              live_slots++;
              b.slot   = IDX_W'(i);
              b.status = STS_OK;
            end
          end
          if (b.status == STS_FULL) full_replies++;
        end
        awaited_beats.push_back(b);
      end
      KIND_START, KIND_CANCEL, KIND_RETIME, KIND_FREE: begin
        if (c.idx >= SLOT_CNT) begin
          b.status = STS_NOT_ALLOC;
        end else if (c.kind == KIND_RETIME) begin
          if (c.period > TICK_MS_DEF) begin
            tbl_period[c.idx] = c.period;
            tbl_left[c.idx]   = int'(c.period / TICK_MS_DEF);
          end
        end else if (!tbl_used[c.idx]) begin
          b.status = STS_NOT_ALLOC;
        end else if (c.kind == KIND_START) begin
          tbl_endless[c.idx] = c.endless;
          if (!c.endless && c.count != 0) tbl_reps[c.idx] = c.count;
          tbl_armed[c.idx] = 1'b1;
        end else if (c.kind == KIND_CANCEL) begin
          tbl_armed[c.idx] = 1'b0;
        end else begin
          tbl_used[c.idx] = 1'b0;
          if (live_slots != 0) live_slots--;
        end
        awaited_beats.push_back(b);
      end
      default: ;
    endcase
  endtask

  // accept side of the driver
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      cmd_taken = 1'b1;
      cmds_taken++;
      advance_table(cmd_on_bus);
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || cmd_taken) begin
        if (pending_cmds.size() != 0 && idle_cycles >= pending_cmds[0].gap) begin
          cmd_on_bus = pending_cmds.pop_front();
          in_kind           <= cmd_on_bus.kind;
          in_timer_index    <= cmd_on_bus.idx;
          in_period_ms      <= cmd_on_bus.period;
          in_repeat_forever <= cmd_on_bus.endless;
          in_repeat_count   <= cmd_on_bus.count;
          in_elapsed_ticks  <= cmd_on_bus.elapsed;
          start             <= 1'b1;
          idle_cycles = 0;
        end else begin
          start <= 1'b0;
          if (pending_cmds.size() != 0 && (!pending_cmds[0].idle_only || !busy))
            idle_cycles++;
        end
      end
      cmd_taken = 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    timer_beat_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_beats.size() == 0) begin
        flag_mismatch("beat with nothing awaited, slot", out_slot, 0);
      end else begin
        want = awaited_beats.pop_front();
        beats_checked++;
        if (out_status !== want.status) flag_mismatch("status", out_status, want.status);
        if (out_slot !== want.slot) flag_mismatch("slot", out_slot, want.slot);
        if (out_event_res !== want.evt) flag_mismatch("event", out_event_res, want.evt);
        if (out_last !== want.last) flag_mismatch("last", out_last, want.last);
      end
    end
  end

  initial begin
    int          roll;
    int          wait_cycles;
    logic [2:0]  k;
    for (int i = 0; i < SLOT_CNT; i++) begin
      tbl_used[i]    = 1'b0;
      tbl_armed[i]   = 1'b0;
      tbl_endless[i] = 1'b0;
      tbl_period[i]  = '0;
      tbl_left[i]    = 0;
      tbl_reps[i]    = '0;
    end
    live_slots = 0;
    rush       = 1'b0;

    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_ALLOC,  4'd0,  20'd0,       1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_ALLOC,  4'd0,  20'd10,      1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_ALLOC,  4'd0,  20'd11,      1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_ALLOC,  4'd0,  20'hFFFFF,   1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_START,  4'd0,  20'd0,       1'b0, 16'd2,     16'd0);
    queue_cmd(KIND_START,  4'd1,  20'd0,       1'b1, 16'd0,     16'd0);
    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'd1);
    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'd3);
    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'd4);
    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'hFFFF);
    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'hFFFF);
    queue_cmd(KIND_START,  4'd15, 20'd0,       1'b1, 16'hFFFF,  16'd0);
    queue_cmd(KIND_CANCEL, 4'd14, 20'd0,       1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_FREE,   4'd13, 20'd0,       1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_RETIME, 4'd15, 20'd20,      1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_RETIME, 4'd1,  20'd5,       1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_RETIME, 4'd1,  20'd25,      1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_ALLOC,  4'd0,  20'd30,      1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_START,  4'd0,  20'd0,       1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'd2);
    queue_cmd(KIND_TICK,   4'd0,  20'd0,       1'b0, 16'd0,     16'd5);
    queue_cmd(KIND_START,  4'd1,  20'd0,       1'b0, 16'hFFFF,  16'd0);
    queue_cmd(KIND_FREE,   4'd1,  20'd0,       1'b0, 16'd0,     16'd0);
    queue_cmd(KIND_RSVD_A, 4'd3,  20'd100,     1'b1, 16'd1,     16'd1);
    queue_cmd(KIND_RSVD_B, 4'd3,  20'd100,     1'b1, 16'd1,     16'd1);

    while (pending_cmds.size() < ITEMS_WANTED) begin
      if ($urandom_range(0, 24) == 0) rush = !rush;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        repeat (SLOT_CNT + 1)
          queue_cmd(KIND_ALLOC, IDX_W'($urandom),
                    PERIOD_W'($urandom_range(TICK_MS_DEF + 1, 30 * TICK_MS_DEF)),
                    1'($urandom), CNT_W'($urandom), CNT_W'($urandom));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 34) k = KIND_TICK;
        else if (roll < 48) k = KIND_ALLOC;
        else if (roll < 66) k = KIND_START;
        else if (roll < 73) k = KIND_CANCEL;
        else if (roll < 80) k = KIND_RETIME;
        else if (roll < 91) k = KIND_FREE;
        else if (roll < 95) k = $urandom_range(0, 1) ? KIND_RSVD_A : KIND_RSVD_B;
        else k = KIND_TICK;
        queue_cmd(k, IDX_W'($urandom), pick_period(), ($urandom_range(0, 3) == 0),
                  pick_count(), pick_elapsed());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    wait_cycles = 0;
    while (awaited_beats.size() != 0 && wait_cycles < 400) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (awaited_beats.size() != 0)
      flag_mismatch("beats never delivered", 0, awaited_beats.size());

    $display("sent %0d commands and ticks, checked %0d result beats",
             cmds_taken, beats_checked);
    $display("covered %0d fires, %0d expiries, %0d full-table replies, %0d catch-up ticks",
             fires_seen, expiries_seen, full_replies, catchup_ticks);
    if (mismatches == 0) begin
      $display("multi_channel_software_timer_table_top_test OK");
    end else begin
      $display("multi_channel_software_timer_table_top_test NOT OK");
    end
    $finish;
  end

endmodule
